[sv/rcpfa_pkg.sv]
// Package for the reference-counted page frame allocator.
// Holds sizes, action and status codes, request and response structs and the sequencer states.
// No dependencies.
`default_nettype none

package rcpfa_pkg;

    localparam int MAX_FRAMES = 8192;
    localparam int COUNT_BITS = 8;

    localparam int ADDR_W  = $clog2(MAX_FRAMES);
    localparam int REG_W   = 14;
    localparam int FRAME_W = 13;
    localparam int CNTO_W  = 8;
    localparam int CMP_W   = (ADDR_W + 1 > REG_W) ? ADDR_W + 1 : REG_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USER   = 2'd1;

    localparam logic [REG_W-1:0] TOTAL_FRAMES_RST = 14'd8192;
    localparam logic [REG_W-1:0] FIRST_USER_RST   = 14'd4097;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_SHARE   = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_NOMEM = 3'd1;
    localparam logic [2:0] STAT_RANGE = 3'd2;
    localparam logic [2:0] STAT_FREE  = 3'd3;
    localparam logic [2:0] STAT_COUNT = 3'd4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [1:0]         action;
        logic [FRAME_W-1:0] frame;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic [FRAME_W-1:0] frame_out;
        logic [CNTO_W-1:0]  count_after;
    } t_resp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RMW,
        S_RESP
    } t_state;

    // Low bits of a count as reported in the response.
    function automatic logic [CNTO_W-1:0] count_out(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS+CNTO_W-1:0] w;
        w = {{CNTO_W{1'b0}}, c};
        return w[CNTO_W-1:0];
    endfunction

    // Memory address reported as a frame field.
    function automatic logic [FRAME_W-1:0] addr_to_frame(input logic [ADDR_W-1:0] a);
        logic [CMP_W-1:0] w;
        w = CMP_W'(a);
        return w[FRAME_W-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/rcpfa_ram.sv]
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// No dependencies.
`default_nettype none

module rcpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[sv/refcounted_page_frame_allocator.sv]
// Top level of the reference-counted page frame allocator: sequencer, config registers, output.
// Depends on rcpfa_pkg and rcpfa_ram.
`default_nettype none

// Channel   Direction  Handshake                    Payload
// request   in         i_in_valid / o_in_ready      i_in  (t_req: action, frame)
// response  out        o_out_valid / i_out_ready    o_out (t_resp: status, frame_out, count_after)
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// After reset the count memory is cleared one entry a cycle, all MAX_FRAMES (8192) entries;
// no request is taken meanwhile, though configuration writes are.
// An allocate scans the count memory from first_user_frame upward through its single read
// port, one frame a cycle, until a free frame is found or the limit is reached; an empty
// window fails at once. Share and release read the count as the request is taken, then
// modify-write and respond; a rejected request goes straight to the response step.
// One request is in flight at a time; a finished response waits in the output register
// while the next request is taken and worked on up to its own response.

module refcounted_page_frame_allocator
    import rcpfa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_req                 i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_resp                     o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [REG_W-1:0]     i_cfg_data
);

    t_state r_state, n_state;

    logic [REG_W-1:0] r_total_frames;
    logic [REG_W-1:0] r_first_user;

    // Request being worked on, scan pointer and the frame whose read data is due.
    t_req              r_req, n_req;
    logic [CMP_W-1:0]  r_scan, n_scan;
    logic              r_chk_vld, n_chk_vld;
    logic [ADDR_W-1:0] r_chk_addr, n_chk_addr;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    t_resp             r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_resp             r_out, n_out;

    // Count memory ports.
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [COUNT_BITS-1:0] mem_rdata;

    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] in_frame_w;
    logic             in_frame_ok;
    logic             in_accept;
    logic             out_free;
    logic             clr_last;
    logic             scan_issue;
    logic             scan_hit;
    logic [CMP_W-1:0] req_frame_w;

    rcpfa_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(MAX_FRAMES)
    ) u_counts (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // The usable frame limit is the smaller of the configured total and the memory depth.
    assign limit = (CMP_W'(r_total_frames) < CMP_W'(MAX_FRAMES))
                 ? CMP_W'(r_total_frames) : CMP_W'(MAX_FRAMES);

    assign in_frame_w  = CMP_W'(i_in.frame);
    assign in_frame_ok = (in_frame_w >= CMP_W'(r_first_user)) && (in_frame_w < limit);
    assign req_frame_w = CMP_W'(r_req.frame);

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign clr_last    = (r_clr_addr == ADDR_W'(MAX_FRAMES - 1));

    // The scan compares one candidate a cycle: a fresh read is issued while the pointer is
    // below the limit, and the data of the previous candidate is checked for a free count.
    assign scan_issue  = (r_scan < limit);
    assign scan_hit    = r_chk_vld && (mem_rdata == '0);

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    priority if (i_in.action == ACT_ALLOC) begin
                        n_state = S_SCAN;
                    end else if (i_in.action == ACT_SHARE || i_in.action == ACT_RELEASE) begin
                        n_state = in_frame_ok ? S_RMW : S_RESP;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit || (!r_chk_vld && !scan_issue)) begin
                    n_state = S_RESP;
                end
            end
            S_RMW: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath control and memory accesses.
    always_comb begin
        n_req       = r_req;
        n_scan      = r_scan;
        n_chk_vld   = 1'b0;
        n_chk_addr  = r_chk_addr;
        n_clr_addr  = r_clr_addr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_waddr   = r_chk_addr;
        mem_wdata   = '0;
        mem_raddr   = r_scan[ADDR_W-1:0];

        unique case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
            end
            S_IDLE: begin
                mem_raddr = in_frame_w[ADDR_W-1:0];
                if (in_accept) begin
                    n_req  = i_in;
                    n_scan = CMP_W'(r_first_user);
                    n_res  = '{status: STAT_RANGE, frame_out: i_in.frame, count_after: '0};
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    // Claim the first free frame with a count of one.
                    mem_we    = 1'b1;
                    mem_waddr = r_chk_addr;
                    mem_wdata = COUNT_BITS'(1);
                    n_res     = '{status: STAT_OK, frame_out: addr_to_frame(r_chk_addr),
                                  count_after: count_out(COUNT_BITS'(1))};
                end else if (!r_chk_vld && !scan_issue) begin
                    n_res = '{status: STAT_NOMEM, frame_out: '0, count_after: '0};
                end else if (scan_issue) begin
                    n_chk_vld  = 1'b1;
                    n_chk_addr = r_scan[ADDR_W-1:0];
                    n_scan     = r_scan + CMP_W'(1);
                end
            end
            S_RMW: begin
                mem_waddr = req_frame_w[ADDR_W-1:0];
                n_res.frame_out = r_req.frame;
                if (r_req.action == ACT_SHARE) begin
                    priority if (mem_rdata == '0) begin
                        n_res.status      = STAT_FREE;
                        n_res.count_after = '0;
                    end else if (mem_rdata == COUNT_MAX) begin
                        n_res.status      = STAT_COUNT;
                        n_res.count_after = count_out(mem_rdata);
                    end else begin
                        mem_we            = 1'b1;
                        mem_wdata         = mem_rdata + COUNT_BITS'(1);
                        n_res.status      = STAT_OK;
                        n_res.count_after = count_out(mem_rdata + COUNT_BITS'(1));
                    end
                end else begin
                    if (mem_rdata == '0) begin
                        n_res.status      = STAT_COUNT;
                        n_res.count_after = '0;
                    end else begin
                        mem_we            = 1'b1;
                        mem_wdata         = mem_rdata - COUNT_BITS'(1);
                        n_res.status      = STAT_OK;
                        n_res.count_after = count_out(mem_rdata - COUNT_BITS'(1));
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_chk_vld   <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk_vld   <= n_chk_vld;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_scan     <= n_scan;
        r_chk_addr <= n_chk_addr;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // Configuration registers; writes to an index beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_frames <= TOTAL_FRAMES_RST;
            r_first_user   <= FIRST_USER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_TOTAL_FRAMES) begin
                r_total_frames <= i_cfg_data;
            end else if (i_cfg_index == CFG_FIRST_USER) begin
                r_first_user <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

[dv/rcpfa_tb_pkg.sv]
// Scoreboard for the reference-counted page frame allocator testbench.
// Keeps its own copy of the count table and registers and checks responses in order.
// Depends on rcpfa_pkg.

package rcpfa_tb_pkg;

    import rcpfa_pkg::*;

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    class frame_table_scoreboard;

        logic [COUNT_BITS-1:0] counts [MAX_FRAMES];
        logic [REG_W-1:0]      total_frames;
        logic [REG_W-1:0]      first_user;
        t_resp                 expected_q [$];
        t_resp                 last_resp;
        int unsigned           mismatches;

        function new();
            foreach (counts[i]) counts[i] = '0;
            total_frames = TOTAL_FRAMES_RST;
            first_user   = FIRST_USER_RST;
            mismatches   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [REG_W-1:0] data);
            if (index == CFG_TOTAL_FRAMES) begin
                total_frames = data;
            end else if (index == CFG_FIRST_USER) begin
                first_user = data;
            end
        endfunction

        function int unsigned limit();
            return (int'(total_frames) < MAX_FRAMES) ? int'(total_frames) : MAX_FRAMES;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Works out the response to one accepted request and updates the table.
        function void note_request(t_req r);
            t_resp       e;
            int unsigned fr;
            int unsigned lim;
            int unsigned fu;
            logic [COUNT_BITS-1:0] c;
            fr  = r.frame;
            lim = limit();
            fu  = first_user;
            e   = '{status: STAT_NOMEM, frame_out: '0, count_after: '0};
            if (r.action == ACT_ALLOC) begin
                for (int unsigned i = fu; i < lim; i++) begin
                    if (counts[i] == '0) begin
                        counts[i] = COUNT_BITS'(1);
                        e = '{status: STAT_OK, frame_out: FRAME_W'(i), count_after: 8'd1};
                        break;
                    end
                end
            end else if (r.action == ACT_UNKNOWN || fr < fu || fr >= lim) begin
                e = '{status: STAT_RANGE, frame_out: r.frame, count_after: '0};
            end else if (r.action == ACT_SHARE) begin
                c = counts[fr];
                if (c == '0) begin
                    e = '{status: STAT_FREE, frame_out: r.frame, count_after: '0};
                end else if (c == COUNT_MAX) begin
                    e = '{status: STAT_COUNT, frame_out: r.frame, count_after: CNTO_W'(c)};
                end else begin
                    counts[fr] = c + 1'b1;
                    e = '{status: STAT_OK, frame_out: r.frame, count_after: CNTO_W'(c + 1'b1)};
                end
            end else begin
                c = counts[fr];
                if (c == '0) begin
                    e = '{status: STAT_COUNT, frame_out: r.frame, count_after: '0};
                end else begin
                    counts[fr] = c - 1'b1;
                    e = '{status: STAT_OK, frame_out: r.frame, count_after: CNTO_W'(c - 1'b1)};
                end
            end
            last_resp = e;
            expected_q.push_back(e);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            mismatches++;
            if (mismatches <= 100) begin
                $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            end
        endtask

        task check_response(t_resp got);
            t_resp want;
            if (expected_q.size() == 0) begin
                report_mismatch("response with nothing outstanding", got.status, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.status != want.status) begin
                report_mismatch("status", got.status, want.status);
            end
            if (got.frame_out != want.frame_out) begin
                report_mismatch("frame_out", got.frame_out, want.frame_out);
            end
            if (got.count_after != want.count_after) begin
                report_mismatch("count_after", got.count_after, want.count_after);
            end
        endtask

    endclass

endpackage

[dv/tb_top.sv]
// Top of the testbench for refcounted_page_frame_allocator: clock, reset, drivers and checks.
// Depends on rcpfa_pkg, rcpfa_tb_pkg and the allocator RTL.

module tb_top;

    import rcpfa_pkg::*;
    import rcpfa_tb_pkg::*;

    // Spare register indexes; writes to them must leave both registers alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // The longest quiet stretch of a correct run is the clearing pass after reset or a scan
    // across the whole table, plus a receiver hold-off. The watchdog allows several times
    // that.
    localparam int unsigned WATCHDOG_LIMIT = 50000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned ITEM_TARGET    = 1150;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                 i_clk       = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    t_req                 in_bits     = '0;
    logic                 out_ready   = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [REG_W-1:0]     cfg_data    = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_resp                o_out;
    logic                 o_cfg_ready;

    frame_table_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned items_sent    = 0;

    refcounted_page_frame_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_bits),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Response side. Every accepted response is checked against the oldest outstanding
    // prediction. Ready is chosen afresh each cycle, except during a long hold-off counted down
    // from HOLD_CYCLES, when it stays low so that the block fills up and stops taking requests.
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            sb.check_response(o_out);
        end
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // The watchdog ends the run if no handshake of any channel completes for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("refcounted_page_frame_allocator regression: fail");
        $finish;
    end

    // Offers one request, possibly after an idle gap, and waits for it to be taken. Valid
    // is left high afterwards; the next call either keeps it high with new contents or
    // drops it for a gap, so it is never lowered and raised in the same step.
    task automatic send_request(input t_req r);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_bits  <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(r);
        items_sent++;
    endtask

    // Stops offering requests and waits for every outstanding response, so that the block
    // is idle before the registers are touched.
    task automatic drain_responses();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes a spare index with junk, then both registers, holding valid high throughout.
    task automatic program_range(input logic [REG_W-1:0] total, input logic [REG_W-1:0] first);
        cfg_valid <= 1'b1;
        cfg_index <= ($urandom_range(1) != 0) ? CFG_SPARE_B : CFG_SPARE_A;
        cfg_data  <= REG_W'($urandom);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(cfg_index, cfg_data);
        cfg_index <= CFG_TOTAL_FRAMES;
        cfg_data  <= total;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(CFG_TOTAL_FRAMES, total);
        cfg_index <= CFG_FIRST_USER;
        cfg_data  <= first;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(CFG_FIRST_USER, first);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                stall_pct    <= 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 63;
                stall_pct    <= 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                stall_pct    <= 63;
            end
            default: begin
                send_idle_pct = 15;
                stall_pct    <= 15;
            end
        endcase
    endtask

    // Mostly well-formed traffic: allocations, and shares and releases that usually pick a
    // frame inside the user window; the rest is unknown actions and stray frames.
    function automatic t_req random_request();
        t_req        r;
        int unsigned lim;
        int unsigned fu;
        int unsigned pick;
        lim     = sb.limit();
        fu      = sb.first_user;
        pick    = $urandom_range(99);
        r.frame = FRAME_W'($urandom);
        if (pick < 30) begin
            r.action = ACT_ALLOC;
        end else if (pick < 92) begin
            r.action = (pick < 61) ? ACT_SHARE : ACT_RELEASE;
            if (fu < lim && $urandom_range(99) < 85) begin
                r.frame = FRAME_W'($urandom_range(fu, lim - 1));
            end
        end else begin
            r.action = ACT_UNKNOWN;
        end
        return r;
    endfunction

    // Takes one frame up to the saturated count and back down past zero, so that both
    // the saturation refusal and the underflow refusal are seen on a well-used frame.
    task automatic saturate_one_frame();
        logic [FRAME_W-1:0] f;
        send_request('{action: ACT_ALLOC, frame: FRAME_W'($urandom)});
        if (sb.last_resp.status != STAT_OK) return;
        f = sb.last_resp.frame_out;
        while (sb.counts[f] != COUNT_MAX) send_request('{action: ACT_SHARE, frame: f});
        repeat (2) send_request('{action: ACT_SHARE, frame: f});
        while (sb.counts[f] != '0) send_request('{action: ACT_RELEASE, frame: f});
        send_request('{action: ACT_RELEASE, frame: f});
    endtask

    initial begin : stimulus
        int unsigned      phase;
        int unsigned      n;
        logic [REG_W-1:0] total;
        logic [REG_W-1:0] first;
        t_idle_mode       mode;

        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed part. The reset window runs from 4097 to the top of the table; the
        // requests wait out the clearing pass through the ready handshake.
        set_idle_mode(IDLE_NONE);
        send_request('{action: ACT_SHARE,   frame: 13'd4097});   // share of a free frame
        send_request('{action: ACT_RELEASE, frame: 13'd4097});   // release underflow
        send_request('{action: ACT_SHARE,   frame: 13'd0});      // below the user window
        send_request('{action: ACT_RELEASE, frame: 13'd8191});   // top frame, still free
        send_request('{action: ACT_UNKNOWN, frame: 13'd8191});   // unknown action
        send_request('{action: ACT_ALLOC,   frame: 13'd8191});   // frame ignored
        send_request('{action: ACT_SHARE,   frame: 13'd4097});
        send_request('{action: ACT_RELEASE, frame: 13'd4097});
        send_request('{action: ACT_RELEASE, frame: 13'd4097});
        send_request('{action: ACT_ALLOC,   frame: 13'd0});
        send_request('{action: ACT_ALLOC,   frame: 13'd0});
        drain_responses();

        // No frames at all: allocation finds nothing and every frame is out of range.
        program_range(14'd0, 14'd0);
        send_request('{action: ACT_ALLOC, frame: 13'd0});
        send_request('{action: ACT_SHARE, frame: 13'd0});
        drain_responses();

        // First user frame at the limit gives an empty window.
        program_range(14'd8192, 14'd8192);
        send_request('{action: ACT_ALLOC,   frame: 13'd0});
        send_request('{action: ACT_RELEASE, frame: 13'd8191});
        drain_responses();

        // A frame count above the table size is clipped to the table.
        program_range(14'd16383, 14'd8191);
        send_request('{action: ACT_ALLOC,   frame: 13'd0});
        send_request('{action: ACT_ALLOC,   frame: 13'd0});      // window now exhausted
        send_request('{action: ACT_RELEASE, frame: 13'd8191});
        drain_responses();

        // A single-frame window starting at frame zero.
        program_range(14'd1, 14'd0);
        send_request('{action: ACT_ALLOC,   frame: 13'd0});
        send_request('{action: ACT_ALLOC,   frame: 13'd0});
        send_request('{action: ACT_SHARE,   frame: 13'd0});
        send_request('{action: ACT_RELEASE, frame: 13'd0});
        drain_responses();

        // Inverted window.
        program_range(14'd4, 14'd10);
        send_request('{action: ACT_ALLOC, frame: 13'd0});
        send_request('{action: ACT_SHARE, frame: 13'd5});

        // Random part. Each phase picks a window and an idling pattern; most windows are
        // small so that allocation scans stay short and frames get reused, and every
        // eighth window is taken from the whole register range.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            drain_responses();
            if (phase % 8 == 7) begin
                total = REG_W'($urandom);
                first = REG_W'($urandom);
                n     = 20;
            end else begin
                first = REG_W'($urandom_range(0, 8190));
                total = first + REG_W'($urandom_range(1, 20));
                n     = $urandom_range(40, 120);
            end
            program_range(total, first);
            mode = t_idle_mode'(phase % 4);
            set_idle_mode(mode);
            // Long receiver hold-off while the sender keeps offering requests.
            if (phase == 0 || $urandom_range(3) == 0) begin
                hold_requests <= hold_requests + 1;
            end
            if (phase == 2) begin
                saturate_one_frame();
            end else begin
                repeat (n) send_request(random_request());
            end
            phase++;
        end

        drain_responses();
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("refcounted_page_frame_allocator regression: pass");
        end else begin
            $display("refcounted_page_frame_allocator regression: fail");
        end
        $finish;
    end

endmodule

[refcounted_page_frame_allocator.f]
sv/rcpfa_pkg.sv
sv/rcpfa_ram.sv
sv/refcounted_page_frame_allocator.sv
dv/rcpfa_tb_pkg.sv
dv/tb_top.sv
